// ----- sv/qfts_pkg.sv -----
// Shared types, widths and codes for the two-stack queue unit.
package qfts_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;

    localparam int S_TDATA_W = ((ACT_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + STAT_W + 7) / 8) * 8;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ACT_W-1:0]         action_t;
    typedef logic [STAT_W-1:0]        status_t;

    localparam action_t ACT_ENQ  = 2'd0;
    localparam action_t ACT_DEQ  = 2'd1;
    localparam action_t ACT_PEEK = 2'd2;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;

endpackage

// ----- sv/qfts_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module qfts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/queue_from_two_stacks_unit.sv -----
// Top level of the FIFO queue built from an inbound and an outbound stack in RAM.
// Enqueues, unused actions, and dequeues or peeks on an empty queue answer in the next cycle.
// A dequeue or peek with outbound entries answers via the READ state, bound by the RAM read.
// A dequeue or peek on an empty outbound stack moves the inbound entries in XFER and XLAST.
// A new transaction is taken once the previous one is finished and the output can take a result.
// Reset clears both counts and the control state; the stack memories are not cleared.
module queue_from_two_stacks_unit #(
    parameter int DEPTH = qfts_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: action[1:0], value[33:2].
    input  logic [qfts_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: value_out[31:0], status[33:32].
    output logic [qfts_pkg::M_TDATA_W-1:0]  m_tdata
);

    import qfts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] FSM_IDLE  = 2'd0;
    localparam logic [1:0] FSM_READ  = 2'd1;
    localparam logic [1:0] FSM_XFER  = 2'd2;
    localparam logic [1:0] FSM_XLAST = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] in_cnt_reg, in_cnt_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;
    logic          pend_reg, pend_next;
    logic          deq_reg, deq_next;
    logic          m_tvalid_reg, m_tvalid_next;
    data_t         m_value_reg, m_value_next;
    status_t       m_status_reg, m_status_next;

    action_t       s_action;
    data_t         s_value;
    logic          accept;
    logic [CW-1:0] in_cnt_m1;
    logic [CW-1:0] out_cnt_m1;

    logic          in_we;
    logic [AW-1:0] in_waddr;
    logic [AW-1:0] in_raddr;
    data_t         in_rdata;
    logic          out_we;
    logic [AW-1:0] out_waddr;
    logic [AW-1:0] out_raddr;
    data_t         out_rdata;

    assign s_action   = s_tdata[ACT_W-1:0];
    assign s_value    = s_tdata[ACT_W +: DATA_W];
    assign s_tready   = (state_reg == FSM_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign in_cnt_m1  = in_cnt_reg - CW'(1);
    assign out_cnt_m1 = out_cnt_reg - CW'(1);

    assign in_waddr  = in_cnt_reg[AW-1:0];
    assign in_raddr  = in_cnt_m1[AW-1:0];
    assign out_waddr = out_cnt_reg[AW-1:0];
    assign out_raddr = out_cnt_m1[AW-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - STAT_W){1'b0}}, m_status_reg, m_value_reg};

    always_comb begin
        state_next    = state_reg;
        in_cnt_next   = in_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        pend_next     = pend_reg;
        deq_next      = deq_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        in_we         = 1'b0;
        out_we        = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    m_value_next = '0;
                    unique case (s_action) inside
                        ACT_ENQ: begin
                            m_tvalid_next = 1'b1;
                            if (in_cnt_reg == CW'(DEPTH)) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                m_status_next = STAT_OK;
                                in_we         = 1'b1;
                                in_cnt_next   = in_cnt_reg + CW'(1);
                            end
                        end
                        ACT_DEQ, ACT_PEEK: begin
                            deq_next = (s_action == ACT_DEQ);
                            if (in_cnt_reg == '0 && out_cnt_reg == '0) begin
                                m_tvalid_next = 1'b1;
                                m_status_next = STAT_EMPTY;
                            end else if (out_cnt_reg != '0) begin
                                state_next = FSM_READ;
                            end else begin
                                state_next = FSM_XFER;
                                pend_next  = 1'b0;
                            end
                        end
                        default: begin
                            m_tvalid_next = 1'b1;
                            m_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            FSM_READ: begin
                m_tvalid_next = 1'b1;
                m_value_next  = out_rdata;
                m_status_next = STAT_OK;
                if (deq_reg) begin
                    out_cnt_next = out_cnt_m1;
                end
                state_next = FSM_IDLE;
            end
            FSM_XFER: begin
                if (pend_reg) begin
                    out_we       = 1'b1;
                    out_cnt_next = out_cnt_reg + CW'(1);
                end
                in_cnt_next = in_cnt_m1;
                pend_next   = 1'b1;
                if (in_cnt_reg == CW'(1)) begin
                    state_next = FSM_XLAST;
                end
            end
            FSM_XLAST: begin
                out_we = 1'b1;
                if (!deq_reg) begin
                    out_cnt_next = out_cnt_reg + CW'(1);
                end
                m_tvalid_next = 1'b1;
                m_value_next  = in_rdata;
                m_status_next = STAT_OK;
                state_next    = FSM_IDLE;
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            in_cnt_reg   <= '0;
            out_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            deq_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_cnt_reg   <= in_cnt_next;
            out_cnt_reg  <= out_cnt_next;
            pend_reg     <= pend_next;
            deq_reg      <= deq_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    qfts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_in_ram (
        .clk   (aclk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (s_value),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    qfts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_out_ram (
        .clk   (aclk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata (in_rdata),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    a_in_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_cnt_reg <= CW'(DEPTH))
        else $error("Inbound count exceeds the stack depth.");

    a_out_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= CW'(DEPTH))
        else $error("Outbound count exceeds the stack depth.");

    a_xfer_has_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_XFER) |-> (in_cnt_reg != '0))
        else $error("Transfer step with an empty inbound stack.");

    a_xlast_answers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_XLAST) |=> (state_reg == FSM_IDLE && m_tvalid_reg))
        else $error("Transfer end did not present a result.");

endmodule

// ----- dv/tb_queue_from_two_stacks_unit.sv -----
// Self-checking testbench for the two-stack FIFO queue unit with random stalls on both streams.
`timescale 1ns / 1ps

module tb_queue_from_two_stacks_unit;

    import qfts_pkg::*;

    localparam action_t ACT_UNUSED = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

    typedef struct {
        data_t   value_out;
        status_t status;
    } queue_answer_t;

    class fifo_order_predictor;
        localparam int QDEPTH = DEPTH_DEF;

        data_t         inbound_mem[QDEPTH];
        data_t         outbound_mem[QDEPTH];
        int            inbound_fill;
        int            outbound_fill;
        queue_answer_t expected_answers[$];
        int            mismatch_count;

        function new();
            inbound_fill   = 0;
            outbound_fill  = 0;
            mismatch_count = 0;
        endfunction

        function void record_request(action_t act, data_t val);
            queue_answer_t ans;
            ans.value_out = '0;
            ans.status    = STAT_OK;
            case (act) inside
                ACT_ENQ: begin
                    if (inbound_fill >= QDEPTH) begin
                        ans.status = STAT_FULL;
                    end else begin
                        inbound_mem[inbound_fill] = val;
                        inbound_fill++;
                    end
                end
                ACT_DEQ, ACT_PEEK: begin
                    if (inbound_fill == 0 && outbound_fill == 0) begin
                        ans.status = STAT_EMPTY;
                    end else begin
                        // The outbound stack is refilled only when it has run dry.
                        if (outbound_fill == 0) begin
                            while (inbound_fill > 0) begin
                                inbound_fill--;
                                outbound_mem[outbound_fill] = inbound_mem[inbound_fill];
                                outbound_fill++;
                            end
                        end
                        ans.value_out = outbound_mem[outbound_fill - 1];
                        if (act == ACT_DEQ) begin
                            outbound_fill--;
                        end
                    end
                end
                default: begin
                end
            endcase
            expected_answers.push_back(ans);
        endfunction

        function void check_answer(logic [M_TDATA_W-1:0] tdata);
            queue_answer_t want;
            data_t         got_value;
            status_t       got_status;
            got_value  = tdata[DATA_W-1:0];
            got_status = tdata[DATA_W +: STAT_W];
            if (expected_answers.size() == 0) begin
                $error("unexpected result transaction: value_out %0d status %0d",
                       got_value, got_status);
                mismatch_count++;
                return;
            end
            want = expected_answers.pop_front();
            if (got_value !== want.value_out) begin
                $error("value_out: expected %0d, actual %0d", want.value_out, got_value);
                mismatch_count++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got_status);
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return expected_answers.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    fifo_order_predictor queue_model = new();

    int send_quiet_left = 0;
    int recv_quiet_left = 0;
    int answers_taken   = 0;

    queue_from_two_stacks_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    task automatic send_request(action_t act, data_t val);
        int gap;
        if (send_quiet_left > 0) begin
            send_quiet_left--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            send_quiet_left = $urandom_range(20, 60);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 8);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({val, act});
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        queue_model.record_request(act, val);
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return data_t'($urandom());
        endcase
    endfunction

    function automatic action_t pick_action(traffic_mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (roll < 85) return ACT_ENQ;
                if (roll < 93) return ACT_DEQ;
                if (roll < 98) return ACT_PEEK;
                return ACT_UNUSED;
            end
            MIX_DRAIN: begin
                if (roll < 12) return ACT_ENQ;
                if (roll < 80) return ACT_DEQ;
                if (roll < 97) return ACT_PEEK;
                return ACT_UNUSED;
            end
            default: begin
                if (roll < 45) return ACT_ENQ;
                if (roll < 80) return ACT_DEQ;
                if (roll < 96) return ACT_PEEK;
                return ACT_UNUSED;
            end
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(ACT_DEQ, 32'sh12345678);
        send_request(ACT_PEEK, -32'sd1);
        send_request(ACT_UNUSED, 32'sh7fffffff);
        send_request(ACT_ENQ, 32'sh7fffffff);
        send_request(ACT_ENQ, 32'sh80000000);
        send_request(ACT_ENQ, -32'sd1);
        send_request(ACT_ENQ, '0);
        send_request(ACT_PEEK, '0);
        send_request(ACT_DEQ, -32'sd1);
        send_request(ACT_ENQ, 32'sh55555555);
        send_request(ACT_ENQ, 32'shaaaaaaaa);
        send_request(ACT_UNUSED, 32'sh80000000);
        send_request(ACT_DEQ, '0);
        send_request(ACT_DEQ, '0);
        send_request(ACT_DEQ, '0);
        send_request(ACT_PEEK, '0);
        send_request(ACT_DEQ, '0);
        send_request(ACT_DEQ, '0);
        send_request(ACT_PEEK, '0);
        send_request(ACT_DEQ, '0);
        send_request(ACT_PEEK, '0);

        // The first random burst is weighted towards enqueues.
        for (int i = 0; i < 160; i++) begin
            send_request(pick_action(MIX_FILL), pick_value());
        end
        begin
            int           sent_random;
            int           burst_len;
            traffic_mix_t mix;
            sent_random = 160;
            while (sent_random < 1380) begin
                mix       = traffic_mix_t'($urandom_range(0, 2));
                burst_len = $urandom_range(40, 170);
                for (int i = 0; i < burst_len; i++) begin
                    send_request(pick_action(mix), pick_value());
                end
                sent_random += burst_len;
            end
        end

        s_tvalid <= 1'b0;
        while (queue_model.outstanding() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (queue_model.mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int gap;
        forever begin
            if (answers_taken == 600) begin
                // A long stall on the result side backs the unit up into its input.
                gap = 400;
            end else if (recv_quiet_left > 0) begin
                recv_quiet_left--;
                gap = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                recv_quiet_left = $urandom_range(20, 60);
                gap = 0;
            end else begin
                gap = $urandom_range(0, 8);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready && aresetn));
            queue_model.check_answer(m_tdata);
            answers_taken++;
        end
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
sv/qfts_pkg.sv
sv/qfts_ram.sv
sv/queue_from_two_stacks_unit.sv
dv/tb_queue_from_two_stacks_unit.sv
